FILE: hdl/ordered_double_ended_entry_store_defines.svh
// Assertion macros shared by the checker of the ordered entry store.
// Depends on nothing; the using module must declare clk and rst.
`ifndef ORDERED_DOUBLE_ENDED_ENTRY_STORE_DEFINES_SVH
`define ORDERED_DOUBLE_ENDED_ENTRY_STORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define ODES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define ODES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/odes_pkg.sv
// Shared types, codes and widths for the ordered entry store.
// Used by the controller, the datapath, the top level and the checker.
package odes_pkg;

  localparam int DEF_MAX_ENTRIES = 1024;
  localparam int DEF_NUM_CHAINS  = 4;

  localparam int CMD_W    = 3;
  localparam int CHAIN_W  = 2;
  localparam int POS_W    = 10;
  localparam int CRD_W    = 32;
  localparam int KEY_W    = 23;
  localparam int DELTA_W  = 24;
  localparam int STAT_W   = 3;
  localparam int CNT_W    = 11;
  localparam int LIFE_W   = 32;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 23;
  localparam int CAP_W      = 11;

  localparam int IN_TDATA_W  = 160;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 168;
  localparam int OUT_TUSER_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LIMIT = 1'd1;

  localparam logic [CAP_W-1:0] CAP_RESET       = 11'd1024;
  localparam logic [KEY_W-1:0] KEY_LIMIT_RESET = 23'd6553600;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_LOW  = 3'd0,
    CMD_INS_HIGH = 3'd1,
    CMD_INS_MID  = 3'd2,
    CMD_REM_LOW  = 3'd3,
    CMD_REM_HIGH = 3'd4,
    CMD_REM_MID  = 3'd5,
    CMD_ADJUST   = 3'd6,
    CMD_READ     = 3'd7
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 3'd0,
    ST_FEW    = 3'd1,
    ST_ORDER  = 3'd2,
    ST_FULL   = 3'd3,
    ST_BADPOS = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RD_LOW  = 2'd0,
    RD_ENT  = 2'd1,
    RD_HIGH = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic [LIFE_W-1:0]       life;
    logic signed [CRD_W-1:0] z;
    logic signed [CRD_W-1:0] y;
    logic signed [CRD_W-1:0] x;
    logic [KEY_W-1:0]        key;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic    latch;
    logic    set_early;
    logic    set_late;
    logic    upd;
    logic    mv_start;
    logic    mv_step;
    rd_sel_t rd_sel;
    logic    cap_l;
    logic    cap_e;
    logic    cap_h;
    logic    wr_new;
    logic    wr_adj;
    logic    load_out;
  } odes_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_t    cmd;
    status_t early;
    status_t late;
    logic    mv_last;
  } odes_stat_t;

endpackage

FILE: hdl/ordered_double_ended_entry_store.sv
// Ordered double-ended entry store. Each chain keeps entries sorted by a
// Q7.16 key in a circular window of MAX_ENTRIES slots of one shared memory
// with a single write and a single read port. Commands are taken one at a
// time; a result register lets the next command in while the last result
// waits. Middle insert and remove move the shorter side one entry per cycle
// through that memory port pair; the number of entries moved is at most about
// half the chain (an insert moves up to 511 entries at 1024).
// No clearing pass follows reset; the store is usable at once.
module ordered_double_ended_entry_store import odes_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int NUM_CHAINS  = DEF_NUM_CHAINS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // position, x_coord, y_coord, z_coord, new_key, key_delta; zero padded
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // cmd, chain
  input  logic [IN_TUSER_W-1:0]  s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // entry_count, read_x, read_y, read_z, read_key, read_lifetime; zero padded
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // status
  output logic [OUT_TUSER_W-1:0] m_tuser,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  odes_cmd_t  ctl;
  odes_stat_t stat;

  status_t                 res_status;
  logic [CNT_W-1:0]        res_count;
  logic signed [CRD_W-1:0] res_x, res_y, res_z;
  logic [KEY_W-1:0]        res_key;
  logic [LIFE_W-1:0]       res_life;

  odes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .stat      (stat),
    .ctl       (ctl)
  );

  odes_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .NUM_CHAINS  (NUM_CHAINS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_cmd       (s_tuser[2:0]),
    .in_chain     (s_tuser[4:3]),
    .in_position  (s_tdata[9:0]),
    .in_x         (s_tdata[41:10]),
    .in_y         (s_tdata[73:42]),
    .in_z         (s_tdata[105:74]),
    .in_new_key   (s_tdata[128:106]),
    .in_key_delta (s_tdata[152:129]),
    .ctl          (ctl),
    .stat         (stat),
    .res_status   (res_status),
    .res_count    (res_count),
    .res_x        (res_x),
    .res_y        (res_y),
    .res_z        (res_z),
    .res_key      (res_key),
    .res_life     (res_life)
  );

  // Pack the result beat
  assign m_tdata = {6'd0, res_life, res_key, res_z, res_y, res_x, res_count};
  assign m_tuser = res_status;

endmodule

FILE: hdl/odes_ctrl.sv
// Sequencer of the ordered entry store: walks each command through its
// checks, reads, shift loop and result. Depends on odes_pkg.
module odes_ctrl import odes_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  odes_stat_t stat,
  output odes_cmd_t  ctl
);

  typedef enum logic [3:0] {
    S_IDLE, S_CHK, S_RDL, S_RDE, S_RDH, S_EVAL, S_MOVE, S_DRAIN, S_WRITE, S_FIN
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  // Decode state into datapath commands
  always_comb begin
    ctl        = '0;
    ctl.rd_sel = RD_ENT;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        ctl.set_early = 1'b1;
        ctl.rd_sel    = RD_LOW;
        if (stat.early != ST_OK) begin
          state_next = S_FIN;
        end else begin
          case (stat.cmd)
            CMD_REM_LOW, CMD_REM_HIGH: begin
              ctl.upd    = 1'b1;
              state_next = S_FIN;
            end
            CMD_REM_MID: begin
              ctl.mv_start = 1'b1;
              state_next   = S_MOVE;
            end
            default: state_next = S_RDL;
          endcase
        end
      end
      S_RDL: begin
        ctl.cap_l  = 1'b1;
        ctl.rd_sel = RD_ENT;
        state_next = S_RDE;
      end
      S_RDE: begin
        ctl.cap_e  = 1'b1;
        ctl.rd_sel = RD_HIGH;
        state_next = S_RDH;
      end
      S_RDH: begin
        ctl.cap_h  = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: begin
        ctl.set_late = 1'b1;
        state_next   = S_FIN;
        case (stat.cmd)
          CMD_INS_LOW, CMD_INS_HIGH: begin
            if (stat.late == ST_OK) begin
              ctl.wr_new = 1'b1;
              ctl.upd    = 1'b1;
            end
          end
          CMD_INS_MID: begin
            if (stat.late == ST_OK) begin
              ctl.mv_start = 1'b1;
              state_next   = S_MOVE;
            end
          end
          CMD_ADJUST: ctl.wr_adj = 1'b1;
          default: ;
        endcase
      end
      S_MOVE: begin
        ctl.mv_step = 1'b1;
        if (stat.mv_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        ctl.upd    = 1'b1;
        state_next = (stat.cmd == CMD_INS_MID) ? S_WRITE : S_FIN;
      end
      S_WRITE: begin
        ctl.wr_new = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          ctl.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state and the result-valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hdl/odes_dpath.sv
// Datapath of the ordered entry store: entry memory, per-chain start and
// count, configuration, checks, shift addressing and result register.
// Depends on odes_pkg.
module odes_dpath import odes_pkg::*; #(
  parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
  parameter int NUM_CHAINS  = DEF_NUM_CHAINS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [CHAIN_W-1:0]      in_chain,
  input  logic [POS_W-1:0]        in_position,
  input  logic signed [CRD_W-1:0] in_x,
  input  logic signed [CRD_W-1:0] in_y,
  input  logic signed [CRD_W-1:0] in_z,
  input  logic [KEY_W-1:0]        in_new_key,
  input  logic signed [DELTA_W-1:0] in_key_delta,
  input  odes_cmd_t               ctl,
  output odes_stat_t              stat,
  output status_t                 res_status,
  output logic [CNT_W-1:0]        res_count,
  output logic signed [CRD_W-1:0] res_x,
  output logic signed [CRD_W-1:0] res_y,
  output logic signed [CRD_W-1:0] res_z,
  output logic [KEY_W-1:0]        res_key,
  output logic [LIFE_W-1:0]       res_life
);

  localparam int DEPTH = NUM_CHAINS * MAX_ENTRIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(MAX_ENTRIES);
  localparam int CNW   = $clog2(MAX_ENTRIES + 1);
  localparam int XW    = ((CNW > POS_W) ? CNW : POS_W) + 1;
  localparam int CHW   = (NUM_CHAINS > 1) ? $clog2(NUM_CHAINS) : 1;
  localparam logic signed [KEY_W+1:0] NV_ZERO = '0;

  // Logical index to physical slot, wrapping the circular window
  function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] s,
                                            input logic [XW-1:0] idx);
    logic [XW:0] sum;
    sum = (XW+1)'(s) + (XW+1)'(idx);
    if (sum >= (XW+1)'(MAX_ENTRIES)) begin
      sum = sum - (XW+1)'(MAX_ENTRIES);
    end
    return SW'(sum);
  endfunction

  function automatic logic [SW-1:0] inc_slot(input logic [SW-1:0] s);
    return (s == SW'(MAX_ENTRIES - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SW-1:0] dec_slot(input logic [SW-1:0] s);
    return (s == '0) ? SW'(MAX_ENTRIES - 1) : s - 1'b1;
  endfunction

  // Configuration
  logic [CAP_W-1:0] cap_q;
  logic [KEY_W-1:0] klim_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_q  <= CAP_RESET;
      klim_q <= KEY_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAPACITY:  cap_q  <= cfg_data[CAP_W-1:0];
        REG_KEY_LIMIT: klim_q <= cfg_data[KEY_W-1:0];
        default: ;
      endcase
    end
  end

  // Command beat
  cmd_t                    cmd_q;
  logic [CHAIN_W-1:0]      ch_q;
  logic [POS_W-1:0]        pos_q;
  logic signed [CRD_W-1:0] x_q, y_q, z_q;
  logic [KEY_W-1:0]        nk_q;
  logic signed [DELTA_W-1:0] delta_q;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q   <= cmd_t'(in_cmd);
      ch_q    <= in_chain;
      pos_q   <= in_position;
      x_q     <= in_x;
      y_q     <= in_y;
      z_q     <= in_z;
      nk_q    <= in_new_key;
      delta_q <= in_key_delta;
    end
  end

  // Per-chain window
  logic [SW-1:0]  start_q [NUM_CHAINS];
  logic [CNW-1:0] count_q [NUM_CHAINS];
  logic [CHW-1:0] chi;
  logic           ch_ok;
  logic [SW-1:0]  st;
  logic [CNW-1:0] n;
  logic [XW-1:0]  nx, px, capx;
  logic [AW-1:0]  base;

  assign chi   = CHW'(ch_q);
  assign ch_ok = (int'(ch_q) < NUM_CHAINS);
  assign st    = start_q[chi];
  assign n     = count_q[chi];
  assign nx    = XW'(n);
  assign px    = XW'(pos_q);
  assign base  = AW'(chi) * AW'(MAX_ENTRIES);

  // Clamp capacity to 2..MAX_ENTRIES
  always_comb begin
    if (cap_q < CAP_W'(2)) begin
      capx = XW'(2);
    end else if (XW'(cap_q) > XW'(MAX_ENTRIES)) begin
      capx = XW'(MAX_ENTRIES);
    end else begin
      capx = XW'(cap_q);
    end
  end

  // Checks that need no stored key
  status_t early;
  always_comb begin
    early = ST_OK;
    if (!ch_ok) begin
      early = ST_BADPOS;
    end else begin
      case (cmd_q)
        CMD_INS_LOW, CMD_INS_HIGH: begin
          if (nx >= capx) early = ST_FULL;
        end
        CMD_INS_MID: begin
          if (nx < XW'(2) || px < XW'(1) || px > nx - 1'b1) early = ST_BADPOS;
          else if (nx >= capx) early = ST_FULL;
        end
        CMD_REM_LOW, CMD_REM_HIGH: begin
          if (nx < XW'(2)) early = ST_FEW;
        end
        CMD_REM_MID: begin
          if (nx < XW'(2)) early = ST_FEW;
          else if (px < XW'(1) || px > nx - XW'(2)) early = ST_BADPOS;
        end
        default: begin
          if (px >= nx) early = ST_BADPOS;
        end
      endcase
    end
  end

  // Captured neighbor keys and entry
  logic [KEY_W-1:0] kl_q, kh_q;
  entry_t           ent_q;
  entry_t           rdata_q;

  always_ff @(posedge clk) begin
    if (ctl.cap_l) kl_q  <= rdata_q.key;
    if (ctl.cap_e) ent_q <= rdata_q;
    if (ctl.cap_h) kh_q  <= rdata_q.key;
  end

  // Adjusted key and its order check
  logic signed [KEY_W+1:0] nv;
  logic adj_ok, lo_ok, hi_ok, is_last;

  always_comb begin
    nv      = $signed({2'b00, ent_q.key}) + $signed({delta_q[DELTA_W-1], delta_q});
    is_last = (px == nx - 1'b1);
    lo_ok   = (px == '0) ? (nv > NV_ZERO) : (nv > $signed({2'b00, kl_q}));
    hi_ok   = is_last ? 1'b1 : (nv < $signed({2'b00, kh_q}));
    adj_ok  = lo_ok && hi_ok && (nv < $signed({2'b00, klim_q}));
  end

  // Checks against stored keys
  status_t late;
  always_comb begin
    late = ST_OK;
    case (cmd_q)
      CMD_INS_LOW: begin
        if (nk_q >= klim_q || (n != '0 && nk_q >= kh_q)) late = ST_ORDER;
      end
      CMD_INS_HIGH: begin
        if (nk_q >= klim_q || (n != '0 && nk_q <= kl_q)) late = ST_ORDER;
      end
      CMD_INS_MID: begin
        if (nk_q >= klim_q || nk_q <= kl_q || nk_q >= kh_q) late = ST_ORDER;
      end
      CMD_ADJUST: begin
        if (!adj_ok) late = ST_ORDER;
      end
      default: late = ST_OK;
    endcase
  end

  // Shift loop
  logic [SW-1:0]  mv_src;
  logic [CNW-1:0] mv_left;
  logic           mv_up;
  logic           low_q;
  logic           pend;
  logic [AW-1:0]  pend_addr;
  logic           low_ins, low_rem;

  assign low_ins = (px < nx - px);
  assign low_rem = (px < nx - px - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= ctl.mv_step;
    end
    if (ctl.mv_start) begin
      if (cmd_q == CMD_INS_MID) begin
        low_q <= low_ins;
        if (low_ins) begin
          mv_up   <= 1'b1;
          mv_src  <= slot_of(st, '0);
          mv_left <= CNW'(px);
        end else begin
          mv_up   <= 1'b0;
          mv_src  <= slot_of(st, nx - 1'b1);
          mv_left <= CNW'(nx - px);
        end
      end else begin
        low_q <= low_rem;
        if (low_rem) begin
          mv_up   <= 1'b0;
          mv_src  <= slot_of(st, px - 1'b1);
          mv_left <= CNW'(px);
        end else begin
          mv_up   <= 1'b1;
          mv_src  <= slot_of(st, px + 1'b1);
          mv_left <= CNW'(nx - px - 1'b1);
        end
      end
    end else if (ctl.mv_step) begin
      pend_addr <= base + AW'(mv_up ? dec_slot(mv_src) : inc_slot(mv_src));
      mv_src    <= mv_up ? inc_slot(mv_src) : dec_slot(mv_src);
      mv_left   <= mv_left - 1'b1;
    end
  end

  // Update start and count of the addressed chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CHAINS; c++) begin
        start_q[c] <= SW'(MAX_ENTRIES / 2);
        count_q[c] <= '0;
      end
    end else if (ctl.upd && ch_ok) begin
      case (cmd_q)
        CMD_INS_LOW: begin
          start_q[chi] <= dec_slot(st);
          count_q[chi] <= n + 1'b1;
        end
        CMD_INS_HIGH: count_q[chi] <= n + 1'b1;
        CMD_INS_MID: begin
          if (low_q) start_q[chi] <= dec_slot(st);
          count_q[chi] <= n + 1'b1;
        end
        CMD_REM_LOW: begin
          start_q[chi] <= inc_slot(st);
          count_q[chi] <= n - 1'b1;
        end
        CMD_REM_HIGH: count_q[chi] <= n - 1'b1;
        CMD_REM_MID: begin
          if (low_q) start_q[chi] <= inc_slot(st);
          count_q[chi] <= n - 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Read address
  logic [SW-1:0] rd_slot;
  logic [AW-1:0] raddr;

  always_comb begin
    case (ctl.rd_sel)
      RD_LOW:  rd_slot = (cmd_q == CMD_INS_HIGH) ? slot_of(st, nx - 1'b1)
                                                 : slot_of(st, px - 1'b1);
      RD_HIGH: begin
        if (cmd_q == CMD_INS_LOW) rd_slot = slot_of(st, '0);
        else if (cmd_q == CMD_INS_MID) rd_slot = slot_of(st, px);
        else rd_slot = slot_of(st, px + 1'b1);
      end
      default: rd_slot = slot_of(st, px);
    endcase
    raddr = ctl.mv_step ? base + AW'(mv_src) : base + AW'(rd_slot);
  end

  // Write port: shifted entry, new entry or adjusted entry
  logic          wen;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [SW-1:0] new_slot;
  logic [KEY_W-1:0]  adj_key;
  logic [LIFE_W-1:0] adj_life;

  assign adj_key  = adj_ok ? nv[KEY_W-1:0] : ent_q.key;
  assign adj_life = (ent_q.life == '1) ? ent_q.life : ent_q.life + 1'b1;

  always_comb begin
    case (cmd_q)
      CMD_INS_LOW:  new_slot = dec_slot(st);
      CMD_INS_HIGH: new_slot = slot_of(st, nx);
      default:      new_slot = slot_of(st, px);
    endcase
    wen   = 1'b0;
    waddr = base + AW'(new_slot);
    wdata = rdata_q;
    if (pend) begin
      wen   = 1'b1;
      waddr = pend_addr;
    end else if (ctl.wr_new) begin
      wen   = 1'b1;
      wdata = '{life: '0, z: z_q, y: y_q, x: x_q, key: nk_q};
    end else if (ctl.wr_adj) begin
      wen   = 1'b1;
      waddr = base + AW'(slot_of(st, px));
      wdata = '{life: adj_life, z: ent_q.z, y: ent_q.y, x: ent_q.x, key: adj_key};
    end
  end

  // Entry memory
  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Status and result register
  status_t          status_q;
  logic [KEY_W-1:0] adj_key_q;
  logic             ok_read;

  assign ok_read = (cmd_q == CMD_READ) && (status_q == ST_OK);

  always_ff @(posedge clk) begin
    if (ctl.set_early) status_q <= early;
    if (ctl.set_late)  status_q <= late;
    if (ctl.wr_adj)    adj_key_q <= adj_key;
    if (ctl.load_out) begin
      res_status <= status_q;
      res_count  <= ch_ok ? CNT_W'(n) : '0;
      res_x      <= ok_read ? ent_q.x : '0;
      res_y      <= ok_read ? ent_q.y : '0;
      res_z      <= ok_read ? ent_q.z : '0;
      res_life   <= ok_read ? ent_q.life : '0;
      if (ok_read) begin
        res_key <= ent_q.key;
      end else if (cmd_q == CMD_ADJUST && status_q != ST_BADPOS) begin
        res_key <= adj_key_q;
      end else begin
        res_key <= '0;
      end
    end
  end

  assign stat.cmd     = cmd_q;
  assign stat.early   = early;
  assign stat.late    = late;
  assign stat.mv_last = (mv_left == CNW'(1));

endmodule

FILE: hdl/odes_checker.sv
// Port-level checks of the ordered entry store, bound to the top level.
// Depends on odes_pkg and ordered_double_ended_entry_store_defines.svh.
`include "ordered_double_ended_entry_store_defines.svh"

module odes_checker import odes_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [OUT_TUSER_W-1:0] m_tuser
);

  localparam int RD_LSB   = CNT_W;
  localparam int RD_MSB   = CNT_W + 3 * CRD_W - 1;
  localparam int LIFE_LSB = CNT_W + 3 * CRD_W + KEY_W;
  localparam int LIFE_MSB = LIFE_LSB + LIFE_W - 1;

  `ODES_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat dropped or changed while stalled")

  `ODES_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second command taken while one is in flight")

  `ODES_ASSERT_NOW(a_status_code, m_tvalid, m_tuser <= ST_BADPOS, "status code out of range")

  `ODES_ASSERT_NOW(a_fail_zero, m_tvalid && (m_tuser != ST_OK), (m_tdata[RD_MSB:RD_LSB] == '0) && (m_tdata[LIFE_MSB:LIFE_LSB] == '0), "read fields set on failed command")

endmodule

bind ordered_double_ended_entry_store odes_checker u_odes_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
